// ===== src/pjmsq_pkg.sv =====
// ----------------------------------------------------------------------------
// pjmsq_pkg
// Types and constants shared by the per-joint motion segment queue.
// ----------------------------------------------------------------------------
package pjmsq_pkg;

  localparam int unsigned CURVE_REGS = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FRAC_BITS  = 8;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_RSVD = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INVALID  = 3'd1,
    ST_FULL     = 3'd2,
    ST_DISJOINT = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_TAIL,
    S_COMMIT,
    S_HEAD,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [2:0]         joint;
    logic [7:0]         packet_length;
    logic [7:0]         curve_select;
    logic signed [15:0] offset_y;
    logic signed [15:0] gain_y;
    logic [31:0]        duration_us;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         head_curve;
    logic signed [15:0] head_offset;
    logic signed [15:0] head_gain;
    logic [31:0]        head_duration;
    logic [3:0]         free_slots;
    logic               queue_empty;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         curve;
    logic signed [15:0] offset;
    logic signed [15:0] gain;
    logic [31:0]        duration;
  } seg_t;

  typedef struct packed {
    logic idle;
    logic capture;
    logic look;
    logic mul_end;
    logic commit;
    logic rd_head;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

// ===== src/per_joint_motion_segment_queue_core.sv =====
// ----------------------------------------------------------------------------
// per_joint_motion_segment_queue_core
// Ring queue of motion segments per joint with push, pop and peek commands.
// ----------------------------------------------------------------------------
// One command is in flight at a time. After the transfer of a command the
// block reads the tail slot from the segment memory, performs two join-point
// multiplications, writes the commit, then reads the head slot and loads the
// result into the output register. The next command is taken the cycle after
// the result loads, so no new command is accepted while one is in flight; a
// result held by out_stall_i delays the following load. Curve registers may
// be written at any time the block is idle.
module per_joint_motion_segment_queue_core #(
  parameter int unsigned JOINTS       = 6,
  parameter int unsigned QUEUE_DEPTH  = 8,
  parameter int unsigned CURVE_COUNT  = 4,
  parameter int unsigned PACKET_BYTES = 9
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  pjmsq_pkg::in_item_t              in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output pjmsq_pkg::out_item_t             out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [pjmsq_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [15:0]                      cfg_data_i
);
  import pjmsq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready_o = cmd.idle;
  assign in_stall_o  = !cmd.idle;

  pjmsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pjmsq_dpath #(
    .JOINTS       (JOINTS),
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .CURVE_COUNT  (CURVE_COUNT),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("block took a transfer while not busy afterwards");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> out_valid_o)
    else $error("result load did not raise out_valid_o");

  a_empty_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.queue_empty |->
      out_data_o.free_slots == 4'(QUEUE_DEPTH))
    else $error("empty queue reports wrong free slot count");

  a_empty_head_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.queue_empty |->
      out_data_o.head_curve == '0 && out_data_o.head_duration == '0)
    else $error("empty queue reports a nonzero head segment");

endmodule

// ===== src/pjmsq_ctrl.sv =====
// ----------------------------------------------------------------------------
// pjmsq_ctrl
// Sequencer: steps one item through tail read, join check, commit, head
// read and result load.
// ----------------------------------------------------------------------------
module pjmsq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  pjmsq_pkg::dp_stat_t   stat_i,
  output pjmsq_pkg::ctrl_cmd_t  cmd_o
);
  import pjmsq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.idle = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.look = 1'b1;
        state_d    = S_TAIL;
      end
      S_TAIL: begin
        cmd_o.mul_end = 1'b1;
        state_d       = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_HEAD;
      end
      S_HEAD: begin
        cmd_o.rd_head = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        if (!stat_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== src/pjmsq_dpath.sv =====
// ----------------------------------------------------------------------------
// pjmsq_dpath
// Curve registers, per-joint pointers, segment memory, join multiplier and
// result register.
// ----------------------------------------------------------------------------
module pjmsq_dpath #(
  parameter int unsigned JOINTS       = 6,
  parameter int unsigned QUEUE_DEPTH  = 8,
  parameter int unsigned CURVE_COUNT  = 4,
  parameter int unsigned PACKET_BYTES = 9
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pjmsq_pkg::ctrl_cmd_t               cmd_i,
  output pjmsq_pkg::dp_stat_t                stat_o,
  input  pjmsq_pkg::in_item_t                in_data_i,
  input  logic                               cfg_we_i,
  input  logic [pjmsq_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output pjmsq_pkg::out_item_t               out_data_o
);
  import pjmsq_pkg::*;

  localparam int unsigned SLOTS = JOINTS * QUEUE_DEPTH;
  localparam int unsigned JW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int unsigned PW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  function automatic logic [15:0] join_point(logic signed [31:0] prod,
                                             logic [15:0] offs);
    logic signed [31:0] adj;
    logic signed [31:0] quo;
    adj = prod + (prod[31] ? 32'sd255 : 32'sd0);
    quo = adj >>> FRAC_BITS;
    return quo[15:0] + offs;
  endfunction

  logic signed [15:0] crv_start_q [CURVE_REGS];
  logic signed [15:0] crv_end_q   [CURVE_REGS];
  logic [PW-1:0]      head_q      [JOINTS];
  logic [CW-1:0]      fill_q      [JOINTS];
  seg_t               seg_mem     [SLOTS];

  in_item_t           item_q;
  seg_t               rd_q;
  logic signed [31:0] start_prod_q, end_prod_q;
  status_e            status_q;
  logic               zero_q;
  logic               out_valid_q;
  out_item_t          out_q, out_d;

  logic               joint_ok;
  logic [JW-1:0]      jsel;
  logic [PW-1:0]      hd, hd_inc;
  logic [CW-1:0]      n;
  logic [PW:0]        tail_sum, wr_sum;
  logic [PW-1:0]      tail_idx, wr_idx;
  logic [AW-1:0]      base, rd_addr, wr_addr;
  logic               mem_we, mem_re;
  seg_t               wr_data;
  logic [15:0]        start_v, end_v;
  status_e            st_d;
  logic               zero_d, push_ok, pop_ok;
  logic [CW-1:0]      free_n;

  assign joint_ok = {1'b0, item_q.joint} < 4'(JOINTS);
  assign jsel     = joint_ok ? item_q.joint[JW-1:0] : '0;
  assign hd       = head_q[jsel];
  assign n        = fill_q[jsel];
  assign base     = AW'(32'(jsel) * QUEUE_DEPTH);
  assign hd_inc   = (32'(hd) == QUEUE_DEPTH - 1) ? '0 : hd + 1'b1;

  always_comb begin
    tail_sum = (PW+1)'(hd) + (PW+1)'(n) - 1'b1;
    wr_sum   = (PW+1)'(hd) + (PW+1)'(n);
    tail_idx = (32'(tail_sum) >= QUEUE_DEPTH) ? PW'(32'(tail_sum) - QUEUE_DEPTH)
                                              : tail_sum[PW-1:0];
    wr_idx   = (32'(wr_sum) >= QUEUE_DEPTH) ? PW'(32'(wr_sum) - QUEUE_DEPTH)
                                            : wr_sum[PW-1:0];
  end

  assign start_v = join_point(start_prod_q, item_q.offset_y);
  assign end_v   = join_point(end_prod_q, rd_q.offset);

  always_comb begin
    st_d    = ST_OK;
    zero_d  = 1'b0;
    push_ok = 1'b0;
    pop_ok  = 1'b0;
    if (item_q.op == OP_PUSH && item_q.packet_length != 8'(PACKET_BYTES)) begin
      st_d   = ST_INVALID;
      zero_d = 1'b1;
    end else if (!joint_ok) begin
      st_d   = ST_INVALID;
      zero_d = 1'b1;
    end else if (item_q.op == OP_PUSH) begin
      if (32'(n) >= QUEUE_DEPTH) begin
        st_d = ST_FULL;
      end else if (32'(item_q.curve_select) >= CURVE_COUNT) begin
        st_d = ST_INVALID;
      end else if (n != '0 && end_v != start_v) begin
        st_d = ST_DISJOINT;
      end else begin
        push_ok = 1'b1;
      end
    end else if (item_q.op == OP_POP) begin
      if (n == '0) begin
        st_d = ST_EMPTY;
      end else begin
        pop_ok = 1'b1;
      end
    end
  end

  always_comb begin
    mem_we  = cmd_i.commit && (push_ok || pop_ok);
    mem_re  = cmd_i.look || cmd_i.rd_head;
    wr_addr = base + AW'(push_ok ? wr_idx : hd);
    rd_addr = base + AW'(cmd_i.look ? tail_idx : hd);
    wr_data = '0;
    if (push_ok) begin
      wr_data.curve    = item_q.curve_select;
      wr_data.offset   = item_q.offset_y;
      wr_data.gain     = item_q.gain_y;
      wr_data.duration = item_q.duration_us;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      seg_mem[wr_addr] <= wr_data;
    end
    if (mem_re) begin
      rd_q <= seg_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
    if (cmd_i.look) begin
      start_prod_q <= 32'(crv_start_q[item_q.curve_select[1:0]]) * 32'(item_q.gain_y);
    end
    if (cmd_i.mul_end) begin
      end_prod_q <= 32'(crv_end_q[rd_q.curve[1:0]]) * 32'(rd_q.gain);
    end
    if (cmd_i.commit) begin
      status_q <= st_d;
      zero_q   <= zero_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CURVE_REGS; i++) begin
        crv_start_q[i] <= '0;
        crv_end_q[i]   <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i[CFG_IDX_W-1]) begin
        crv_end_q[cfg_index_i[CFG_IDX_W-2:0]] <= cfg_data_i;
      end else begin
        crv_start_q[cfg_index_i[CFG_IDX_W-2:0]] <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < JOINTS; i++) begin
        head_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      if (push_ok) begin
        fill_q[jsel] <= n + 1'b1;
      end else if (pop_ok) begin
        fill_q[jsel] <= n - 1'b1;
        head_q[jsel] <= hd_inc;
      end
    end
  end

  assign free_n = CW'(QUEUE_DEPTH) - n;

  always_comb begin
    out_d        = '0;
    out_d.status = status_q;
    if (!zero_q) begin
      out_d.free_slots  = 4'(free_n);
      out_d.queue_empty = (n == '0);
      if (n != '0) begin
        out_d.head_curve    = rd_q.curve;
        out_d.head_offset   = rd_q.offset;
        out_d.head_gain     = rd_q.gain;
        out_d.head_duration = rd_q.duration;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_busy = out_valid_q && out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives per_joint_motion_segment_queue_core with push, pop and peek commands
// and compares every result with a model of the per-joint ring queues.
// ----------------------------------------------------------------------------
// Covers rejected pushes, full and empty queues, joint continuity under several
// curve register settings, and random traffic with bursts of idle and stall on
// both sides.
module testbench;
  import pjmsq_pkg::*;

  localparam int unsigned JOINTS       = 6;
  localparam int unsigned QUEUE_DEPTH  = 8;
  localparam int unsigned CURVE_COUNT  = 4;
  localparam int unsigned PACKET_BYTES = 9;
  localparam logic [7:0]  PKT_LEN      = 8'(PACKET_BYTES);

  logic                 clk_i      = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  in_item_t             in_data    = '0;
  logic                 out_stall  = 1'b0;
  logic                 cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [15:0]          cfg_data   = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  out_item_t            out_data_o;
  logic                 cfg_ready_o;

  bit                   idle_on    = 1'b1;
  int unsigned          fail_count = 0;
  int unsigned          stall_left = 0;

  // queue model
  logic [15:0]          curve_first [CURVE_REGS];
  logic [15:0]          curve_last  [CURVE_REGS];
  int unsigned          q_head      [JOINTS];
  int unsigned          q_fill      [JOINTS];
  seg_t                 slot_mem    [JOINTS][QUEUE_DEPTH];
  out_item_t            pending_views[$];

  per_joint_motion_segment_queue_core #(
    .JOINTS      (JOINTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CURVE_COUNT (CURVE_COUNT),
    .PACKET_BYTES(PACKET_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // value * gain / 256 toward zero, plus offset, 16-bit wrap
  function automatic logic [15:0] join_point(logic [15:0] value, logic [15:0] gain,
                                             logic [15:0] offset);
    int          a;
    int          b;
    int          q;
    logic [15:0] low;
    a   = $signed(value);
    b   = $signed(gain);
    q   = (a * b) / 256;
    low = q[15:0];
    return low + offset;
  endfunction

  function automatic logic [15:0] tail_end_of(int unsigned j);
    seg_t tail;
    tail = slot_mem[j][(q_head[j] + q_fill[j] - 1) % QUEUE_DEPTH];
    return join_point(curve_last[tail.curve[1:0]], tail.gain, tail.offset);
  endfunction

  function automatic out_item_t predict_queue_step(in_item_t c);
    out_item_t   r;
    int unsigned j;
    int unsigned hd;
    int unsigned n;
    r = '0;
    if (c.op == OP_PUSH && c.packet_length != PKT_LEN) begin
      r.status = ST_INVALID;
      return r;
    end
    if (c.joint >= JOINTS) begin
      r.status = ST_INVALID;
      return r;
    end
    j  = c.joint;
    hd = q_head[j];
    n  = q_fill[j];
    r.status = ST_OK;
    case (c.op)
      OP_PUSH: begin
        if (n >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else if (c.curve_select >= CURVE_COUNT) begin
          r.status = ST_INVALID;
        end else begin
          if (n != 0 && tail_end_of(j) !=
              join_point(curve_first[c.curve_select[1:0]], c.gain_y, c.offset_y)) begin
            r.status = ST_DISJOINT;
          end
          if (r.status == ST_OK) begin
            slot_mem[j][(hd + n) % QUEUE_DEPTH] =
              '{c.curve_select, c.offset_y, c.gain_y, c.duration_us};
            n = n + 1;
            q_fill[j] = n;
          end
        end
      end
      OP_POP: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot_mem[j][hd] = '0;
          hd = (hd + 1) % QUEUE_DEPTH;
          q_head[j] = hd;
          n = n - 1;
          q_fill[j] = n;
        end
      end
      default: ;
    endcase
    r.head_curve    = slot_mem[j][hd].curve;
    r.head_offset   = slot_mem[j][hd].offset;
    r.head_gain     = slot_mem[j][hd].gain;
    r.head_duration = slot_mem[j][hd].duration;
    r.free_slots    = 4'(QUEUE_DEPTH - n);
    r.queue_empty   = (n == 0);
    return r;
  endfunction

  function automatic in_item_t make_cmd(logic [1:0] op, logic [2:0] joint, logic [7:0] plen,
                                        logic [7:0] csel, logic [15:0] offs,
                                        logic [15:0] gain, logic [31:0] dur);
    in_item_t c;
    c = '{op, joint, plen, csel, offs, gain, dur};
    return c;
  endfunction

  // mostly well-formed pushes that join the tail, plus pops, peeks and noise
  function automatic in_item_t random_cmd(int unsigned push_pct);
    in_item_t    c;
    int unsigned pick;
    int unsigned rest;
    c.joint         = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(JOINTS, 7))
                                                   : 3'($urandom_range(0, JOINTS - 1));
    c.packet_length = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255)) : PKT_LEN;
    c.curve_select  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, CURVE_COUNT - 1));
    c.offset_y      = 16'($urandom);
    c.gain_y        = 16'($urandom);
    c.duration_us   = $urandom;
    pick = $urandom_range(0, 99);
    rest = 100 - push_pct;
    if (pick < push_pct)                 c.op = OP_PUSH;
    else if (pick < push_pct + rest * 3 / 4) c.op = OP_POP;
    else if (pick < 99)                  c.op = OP_PEEK;
    else                                 c.op = OP_RSVD;
    if (c.op == OP_PUSH && c.joint < JOINTS && c.curve_select < CURVE_COUNT &&
        q_fill[c.joint] != 0 && $urandom_range(0, 9) < 8) begin
      c.offset_y = tail_end_of(c.joint) -
                   join_point(curve_first[c.curve_select[1:0]], c.gain_y, 16'h0000);
    end
    return c;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic send_cmd(input in_item_t cmd);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= cmd;
    do @(posedge clk_i); while (in_stall_o);
    pending_views.push_back(predict_queue_step(cmd));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // registers 0..3 curve starts, 4..7 curve ends
  task automatic program_curves(input logic [7:0][15:0] vals);
    for (int i = 0; i < 2 * CURVE_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      if (i < CURVE_REGS) curve_first[i] = vals[i];
      else                curve_last[i - CURVE_REGS] = vals[i];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(int unsigned count, int unsigned push_pct);
    for (int unsigned k = 0; k < count; k++) send_cmd(random_cmd(push_pct));
    drain_results();
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_views.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_views.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    out_data_o.status, want.status));
        if (out_data_o.head_curve !== want.head_curve)
          report_mismatch($sformatf("head_curve got %0h want %0h",
                                    out_data_o.head_curve, want.head_curve));
        if (out_data_o.head_offset !== want.head_offset)
          report_mismatch($sformatf("head_offset got %0h want %0h",
                                    out_data_o.head_offset, want.head_offset));
        if (out_data_o.head_gain !== want.head_gain)
          report_mismatch($sformatf("head_gain got %0h want %0h",
                                    out_data_o.head_gain, want.head_gain));
        if (out_data_o.head_duration !== want.head_duration)
          report_mismatch($sformatf("head_duration got %0h want %0h",
                                    out_data_o.head_duration, want.head_duration));
        if (out_data_o.free_slots !== want.free_slots)
          report_mismatch($sformatf("free_slots got %0d want %0d",
                                    out_data_o.free_slots, want.free_slots));
        if (out_data_o.queue_empty !== want.queue_empty)
          report_mismatch($sformatf("queue_empty got %0b want %0b",
                                    out_data_o.queue_empty, want.queue_empty));
      end
    end
  end

  // reset defaults, rejected pushes, fill to full, reserved op, pops
  task automatic test_edge_commands();
    send_cmd(make_cmd(OP_PEEK, 3'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 32'h0));
    send_cmd(make_cmd(OP_POP,  3'd0, 8'd9, 8'd0, 16'h0000, 16'h0000, 32'h0));
    send_cmd(make_cmd(OP_PUSH, 3'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 32'h0));
    send_cmd(make_cmd(OP_PUSH, 3'd0, 8'd255, 8'd0, 16'hffff, 16'hffff, 32'hffffffff));
    send_cmd(make_cmd(OP_PUSH, 3'd7, PKT_LEN, 8'd0, 16'h0000, 16'h0100, 32'h1));
    send_cmd(make_cmd(OP_POP,  3'd6, 8'd0, 8'd0, 16'h0000, 16'h0000, 32'h0));
    send_cmd(make_cmd(OP_PEEK, 3'd7, 8'd255, 8'd255, 16'hffff, 16'hffff, 32'hffffffff));
    send_cmd(make_cmd(OP_RSVD, 3'd7, 8'd0, 8'd0, 16'h0000, 16'h0000, 32'h0));
    send_cmd(make_cmd(OP_PUSH, 3'd0, PKT_LEN, 8'd4, 16'h0000, 16'h0100, 32'h1));
    send_cmd(make_cmd(OP_PUSH, 3'd0, PKT_LEN, 8'd255, 16'h0000, 16'h0100, 32'h1));
    send_cmd(make_cmd(OP_PUSH, 3'd0, PKT_LEN, 8'd3, 16'h8000, 16'h7fff, 32'hffffffff));
    send_cmd(make_cmd(OP_PUSH, 3'd0, PKT_LEN, 8'd0, 16'h7fff, 16'h8000, 32'h0));
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      send_cmd(make_cmd(OP_PUSH, 3'd0, PKT_LEN, 8'($urandom_range(0, CURVE_COUNT - 1)),
                        16'h8000, 16'($urandom), $urandom));
    end
    send_cmd(make_cmd(OP_PUSH, 3'd0, PKT_LEN, 8'd1, 16'h8000, 16'h0000, 32'h5));
    send_cmd(make_cmd(OP_RSVD, 3'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 32'h0));
    send_cmd(make_cmd(OP_POP,  3'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 32'h0));
    send_cmd(make_cmd(OP_POP,  3'd0, 8'd0, 8'd0, 16'h0000, 16'h0000, 32'h0));
    send_cmd(make_cmd(OP_PUSH, 3'd5, PKT_LEN, 8'd0, 16'h7fff, 16'h8000, 32'h0));
    send_cmd(make_cmd(OP_PEEK, 3'd5, 8'd0, 8'd0, 16'h0000, 16'h0000, 32'h0));
    drain_results();
  endtask

  // extreme register values, so the join products hit both ends of the range
  task automatic test_curve_extremes();
    program_curves({16'h0001, 16'hffff, 16'h7fff, 16'h8000,
                    16'hffff, 16'h0001, 16'h8000, 16'h7fff});
    run_random(80, 60);
    program_curves({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                    16'h8000, 16'h8000, 16'h8000, 16'h8000});
    run_random(80, 55);
  endtask

  task automatic test_random_traffic();
    logic [7:0][15:0] vals;
    for (int p = 0; p < 10; p++) begin
      for (int i = 0; i < 2 * CURVE_REGS; i++) vals[i] = 16'($urandom);
      program_curves(vals);
      idle_on = (p % 4 != 3);
      case (p % 3)
        0:       run_random(135, 75);
        1:       run_random(135, 30);
        default: run_random(135, 55);
      endcase
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    program_curves('0);
    run_random(150, 55);
  endtask

  initial begin
    for (int i = 0; i < CURVE_REGS; i++) begin
      curve_first[i] = '0;
      curve_last[i]  = '0;
    end
    for (int j = 0; j < JOINTS; j++) begin
      q_head[j] = 0;
      q_fill[j] = 0;
      for (int s = 0; s < QUEUE_DEPTH; s++) slot_mem[j][s] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_edge_commands();
    test_curve_extremes();
    test_random_traffic();
    test_steady_stream();

    repeat (16) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
